[hdl/ikhm_pkg.sv]
// Shared codes, widths and controller state type for the integer key hash map.
package ikhm_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int TOTAL_W = 8;

  typedef enum logic [1:0] {
    ACT_PUT      = 2'd0,
    ACT_GET      = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_RESERVED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_HEAD  = 9'b000000010,
    ST_WALK  = 9'b000000100,
    ST_FREAD = 9'b000001000,
    ST_INS1  = 9'b000010000,
    ST_INS2  = 9'b000100000,
    ST_REM1  = 9'b001000000,
    ST_REM2  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

endpackage

[hdl/ikhm_entry_mem.sv]
// Entry pool storage: key/value memory and link/end-of-chain memory, one shared read address.
module ikhm_entry_mem #(
  parameter int DEPTH = 128,
  parameter int IW    = 7
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [IW-1:0]            rd_addr,
  output logic [ikhm_pkg::KEY_W-1:0] rd_key,
  output logic [ikhm_pkg::VAL_W-1:0] rd_val,
  output logic [IW-1:0]            rd_link,
  output logic                     rd_end,
  input  logic                     kv_we,
  input  logic [IW-1:0]            kv_waddr,
  input  logic [ikhm_pkg::KEY_W-1:0] kv_wkey,
  input  logic [ikhm_pkg::VAL_W-1:0] kv_wval,
  input  logic                     lk_we,
  input  logic [IW-1:0]            lk_waddr,
  input  logic [IW-1:0]            lk_wlink,
  input  logic                     lk_wend
);

  logic [ikhm_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [ikhm_pkg::VAL_W-1:0] val_mem [DEPTH];
  logic [IW-1:0]              link_mem [DEPTH];
  logic                       end_mem [DEPTH];

  // Key and value words.
  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[kv_waddr] <= kv_wkey;
      val_mem[kv_waddr] <= kv_wval;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

  // Chain links and end-of-chain flags.
  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wlink;
      end_mem[lk_waddr]  <= lk_wend;
    end
    if (rd_en) begin
      rd_link <= link_mem[rd_addr];
      rd_end  <= end_mem[rd_addr];
    end
  end

endmodule

[hdl/integer_key_hash_map.sv]
// A word passes through the bin head read (ST_HEAD), the chain walk (ST_WALK) and ST_DONE,
// which loads the result into the output register once that is free; an empty bin skips the
// walk, a remove adds ST_REM1 and ST_REM2, and an insert adds ST_INS1 and, as needed, ST_FREAD and ST_INS2.
// One word is in flight at a time; the chain walk uses the single entry memory read port.
// A finished result sits in the output register while the next word is accepted.
// Reset (synchronous, rst_n low) empties all bins and the pool at once; no clearing pass.
module integer_key_hash_map #(
  parameter int NUM_BINS = 64,
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_key,
  input  logic [31:0] in_new_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_value,
  output logic [7:0]  out_entry_total
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  ikhm_pkg::state_t state_r;
  logic [1:0]       act_r;
  logic [31:0]      key_r;
  logic [31:0]      nval_r;
  logic [IW-1:0]    cur_r, prev_r, alloc_r, free_head_r, free_next_r, head_q_r;
  logic             at_head_r;
  logic [IW-1:0]    cur_link_r;
  logic             cur_end_r;
  logic [CW-1:0]    fill_r, count_r;
  logic [NUM_BINS-1:0] bin_valid_r;
  logic [1:0]       res_status_r;
  logic [31:0]      res_val_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_val_r;
  logic [7:0]       out_total_r;

  logic [IW-1:0]    head_mem [NUM_BINS];
  logic [BW-1:0]    bin_r;

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [31:0]      rd_key, rd_val;
  logic [IW-1:0]    rd_link;
  logic             rd_end;
  logic             kv_we, lk_we, lk_wend;
  logic [IW-1:0]    kv_waddr, lk_waddr, lk_wlink;
  logic [31:0]      kv_wval;

  logic             accept;
  logic             hit;
  logic             go_decide;
  logic             dec_found;
  logic [31:0]      dec_val;
  logic             pool_full;
  logic             fresh;
  logic [IW-1:0]    fresh_next;

  assign bin_r      = key_r[BW-1:0];
  assign in_ready   = (state_r == ikhm_pkg::ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign hit        = (rd_key == key_r);
  assign pool_full  = (count_r >= CW'(CAPACITY));
  assign fresh      = (fill_r < CW'(CAPACITY)) && (free_head_r == fill_r[IW-1:0]);
  assign fresh_next = (free_head_r == IW'(CAPACITY - 1)) ? '0 : free_head_r + 1'b1;

  // The lookup ends on an empty bin, a key match or the chain tail.
  always_comb begin
    go_decide = 1'b0;
    dec_found = 1'b0;
    dec_val   = '0;
    if (state_r == ikhm_pkg::ST_HEAD && !bin_valid_r[bin_r]) begin
      go_decide = 1'b1;
    end else if (state_r == ikhm_pkg::ST_WALK && (hit || rd_end)) begin
      go_decide = 1'b1;
      dec_found = hit;
      dec_val   = hit ? rd_val : '0;
    end
  end

  // Memory port control for the walk, the free-list pop and the write-backs.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    kv_we    = 1'b0;
    kv_waddr = cur_r;
    kv_wval  = nval_r;
    lk_we    = 1'b0;
    lk_waddr = cur_r;
    lk_wlink = '0;
    lk_wend  = 1'b0;
    case (state_r)
      ikhm_pkg::ST_HEAD: begin
        if (bin_valid_r[bin_r]) begin
          rd_en   = 1'b1;
          rd_addr = head_q_r;
        end
      end
      ikhm_pkg::ST_WALK: begin
        if (!go_decide) begin
          rd_en   = 1'b1;
          rd_addr = rd_link;
        end
      end
      ikhm_pkg::ST_INS1: begin
        kv_we    = 1'b1;
        kv_waddr = alloc_r;
        lk_we    = 1'b1;
        lk_waddr = alloc_r;
        lk_wend  = 1'b1;
      end
      ikhm_pkg::ST_INS2: begin
        lk_we    = 1'b1;
        lk_wlink = alloc_r;
      end
      ikhm_pkg::ST_REM1: begin
        lk_we    = !at_head_r;
        lk_waddr = prev_r;
        lk_wlink = cur_link_r;
        lk_wend  = cur_end_r;
      end
      ikhm_pkg::ST_REM2: begin
        lk_we    = 1'b1;
        lk_wlink = free_head_r;
      end
      default: begin
      end
    endcase
    // Update in place of a key found by put, or pop of a recycled free entry.
    if (go_decide && act_r == ikhm_pkg::ACT_PUT) begin
      if (dec_found) begin
        kv_we = 1'b1;
      end else if (!pool_full && !fresh) begin
        rd_en   = 1'b1;
        rd_addr = free_head_r;
      end
    end
  end

  ikhm_entry_mem #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_entry_mem (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_val   (rd_val),
    .rd_link  (rd_link),
    .rd_end   (rd_end),
    .kv_we    (kv_we),
    .kv_waddr (kv_waddr),
    .kv_wkey  (key_r),
    .kv_wval  (kv_wval),
    .lk_we    (lk_we),
    .lk_waddr (lk_waddr),
    .lk_wlink (lk_wlink),
    .lk_wend  (lk_wend)
  );

  // Bin head memory; its valid bits live in bin_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_q_r <= head_mem[in_key[BW-1:0]];
    end
    if (state_r == ikhm_pkg::ST_INS1 && !bin_valid_r[bin_r]) begin
      head_mem[bin_r] <= alloc_r;
    end else if (state_r == ikhm_pkg::ST_REM1 && at_head_r && !cur_end_r) begin
      head_mem[bin_r] <= cur_link_r;
    end
  end

  // Word payload and walk pointers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      key_r  <= in_key;
      nval_r <= in_new_value;
    end
    if (state_r == ikhm_pkg::ST_HEAD) begin
      cur_r     <= head_q_r;
      at_head_r <= 1'b1;
    end
    if (state_r == ikhm_pkg::ST_WALK) begin
      if (go_decide) begin
        cur_link_r <= rd_link;
        cur_end_r  <= rd_end;
      end else begin
        prev_r    <= cur_r;
        cur_r     <= rd_link;
        at_head_r <= 1'b0;
      end
    end
    if (go_decide) begin
      alloc_r     <= free_head_r;
      free_next_r <= fresh_next;
    end
    if (state_r == ikhm_pkg::ST_FREAD) begin
      free_next_r <= rd_link;
    end
  end

  // Controller, pool bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ikhm_pkg::ST_IDLE;
      free_head_r  <= '0;
      fill_r       <= '0;
      count_r      <= '0;
      bin_valid_r  <= '0;
      res_status_r <= ikhm_pkg::STS_NOT_FOUND;
      res_val_r    <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ikhm_pkg::STS_OK;
      out_val_r    <= '0;
      out_total_r  <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ikhm_pkg::ST_IDLE: begin
          if (accept) begin
            state_r <= ikhm_pkg::ST_HEAD;
          end
        end
        ikhm_pkg::ST_HEAD: begin
          if (bin_valid_r[bin_r]) begin
            state_r <= ikhm_pkg::ST_WALK;
          end
        end
        ikhm_pkg::ST_FREAD: begin
          state_r <= ikhm_pkg::ST_INS1;
        end
        ikhm_pkg::ST_INS1: begin
          free_head_r <= free_next_r;
          count_r     <= count_r + 1'b1;
          if (!bin_valid_r[bin_r]) begin
            bin_valid_r[bin_r] <= 1'b1;
            state_r            <= ikhm_pkg::ST_DONE;
          end else begin
            state_r <= ikhm_pkg::ST_INS2;
          end
        end
        ikhm_pkg::ST_INS2: begin
          state_r <= ikhm_pkg::ST_DONE;
        end
        ikhm_pkg::ST_REM1: begin
          if (at_head_r && cur_end_r) begin
            bin_valid_r[bin_r] <= 1'b0;
          end
          state_r <= ikhm_pkg::ST_REM2;
        end
        ikhm_pkg::ST_REM2: begin
          free_head_r <= cur_r;
          if (count_r != '0) begin
            count_r <= count_r - 1'b1;
          end
          state_r <= ikhm_pkg::ST_DONE;
        end
        ikhm_pkg::ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_val_r    <= res_val_r;
            out_total_r  <= 8'(count_r);
            state_r      <= ikhm_pkg::ST_IDLE;
          end
        end
        default: begin
        end
      endcase

      // Decide the action once the lookup has finished.
      if (go_decide) begin
        res_status_r <= ikhm_pkg::STS_NOT_FOUND;
        res_val_r    <= '0;
        state_r      <= ikhm_pkg::ST_DONE;
        case (act_r)
          ikhm_pkg::ACT_PUT: begin
            if (dec_found) begin
              res_status_r <= ikhm_pkg::STS_OK;
              res_val_r    <= dec_val;
            end else if (pool_full) begin
              res_status_r <= ikhm_pkg::STS_FULL;
            end else begin
              res_status_r <= ikhm_pkg::STS_OK;
              if (fresh) begin
                fill_r  <= fill_r + 1'b1;
                state_r <= ikhm_pkg::ST_INS1;
              end else begin
                state_r <= ikhm_pkg::ST_FREAD;
              end
            end
          end
          ikhm_pkg::ACT_GET: begin
            if (dec_found) begin
              res_status_r <= ikhm_pkg::STS_OK;
              res_val_r    <= dec_val;
            end
          end
          ikhm_pkg::ACT_REMOVE: begin
            if (dec_found) begin
              res_status_r <= ikhm_pkg::STS_OK;
              res_val_r    <= dec_val;
              state_r      <= ikhm_pkg::ST_REM1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_val_r;
  assign out_entry_total  = out_total_r;

`ifndef ASSERT_OFF
  // The entry count never exceeds the pool.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Entries in use were all taken from the fresh region at some time.
  a_fill_covers: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fill_r)
    else $error("entry count above allocated region");

  // An empty table has no occupied bin.
  a_empty_bins: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && state_r == ikhm_pkg::ST_IDLE) |-> (bin_valid_r == '0))
    else $error("bin marked occupied in empty table");

  // An accepted word always starts with the bin head read.
  a_accept_head: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ikhm_pkg::ST_HEAD))
    else $error("accepted word did not start a lookup");
`endif

endmodule
